FILE: design/mase_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix add/subtract/multiply engine.
// No dependencies; every other file of the block imports this package.
package mase_pkg;

    localparam int unsigned ELEM_W = 32;
    localparam int unsigned IDX_IN_W = 3;
    localparam int unsigned DIM_W = 4;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned RND_W = 48;

    localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IDX = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [2:0] {
        CMD_WRITE_A = 3'd0,
        CMD_READ_A  = 3'd1,
        CMD_WRITE_B = 3'd2,
        CMD_ADD     = 3'd3,
        CMD_SUB     = 3'd4,
        CMD_MUL     = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_IDENT   = 3'd7
    } mase_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_IDENT,
        ST_ADDSUB,
        ST_AS_DRAIN,
        ST_COPY,
        ST_SETTLE,
        ST_MAC,
        ST_MAC_DRAIN,
        ST_FIN
    } mase_state_t;

    // Marks one multiply-accumulate step entering the MAC pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_tag_t;

endpackage

FILE: design/mase_store.sv
`timescale 1ns / 1ps
// One matrix store: synchronous RAM with one write and one registered read port,
// plus a valid bit per entry so unwritten or cleared entries read as zero. Uses mase_pkg.
module mase_store #(
    parameter int unsigned ADDR_W = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [mase_pkg::ELEM_W-1:0] wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [mase_pkg::ELEM_W-1:0] rdata
);
    import mase_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [ELEM_W-1:0] rd_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= valid_reg[raddr];
            if (clear) begin
                valid_reg <= '0;
            end
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

FILE: design/mase_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate pipeline: operand stage, 32x32 product register, rounding
// to Q16.16 and accumulate, then saturation of the finished sum. Uses mase_pkg.
module mase_mac #(
    parameter int unsigned IDX_W = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mase_pkg::mac_tag_t                 tag_in,
    input  logic signed [mase_pkg::ELEM_W-1:0] op_a,
    input  logic signed [mase_pkg::ELEM_W-1:0] op_b,
    output logic                               res_valid,
    output logic [mase_pkg::ELEM_W-1:0]        res_data,
    output logic                               res_sat
);
    import mase_pkg::*;

    localparam int unsigned ACC_W = RND_W + IDX_W;

    mac_tag_t                 tag0_reg;
    mac_tag_t                 tag1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RND_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic                     ovf;

    assign prod_next = op_a * op_b;

    // Round half up: add half an LSB, then drop 16 fraction bits (floor).
    assign prod_rnd = prod_reg + PROD_W'(32'sd32768);
    assign rnd      = prod_rnd[PROD_W-1:16];
    assign acc_next = tag1_reg.first ? ACC_W'(rnd) : acc_reg + ACC_W'(rnd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag0_reg <= tag_in;
            tag1_reg <= tag0_reg;
            done_reg <= tag1_reg.vld && tag1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (tag1_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    // Out of 32-bit range when the bits above bit 31 are not all sign copies.
    assign ovf = !((&acc_reg[ACC_W-1:ELEM_W-1]) || !(|acc_reg[ACC_W-1:ELEM_W-1]));

    assign res_valid = done_reg;
    assign res_sat   = ovf;
    assign res_data  = ovf ? (acc_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : acc_reg[ELEM_W-1:0];

endmodule

FILE: design/matrix_add_sub_multiply_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the matrix engine: command sequencer, size register, row buffer and
// result register around two mase_store RAMs and one mase_mac. Uses mase_pkg.
//
// Usage:
//   Commands enter on the s_ stream (s_tuser = command, s_tdata = row, col, value).
//   Every command returns exactly one transfer on the m_ stream: m_tdata holds the
//   element for a read of A (zero otherwise), m_tuser the status (ok, saturated,
//   index outside the size in use).
//   The size n in use is written through cfg_valid/cfg_data while the block is idle;
//   the user must ensure this, the block does not enforce it. Zero acts as 1 and values
//   above MAX_DIM act as MAX_DIM. cfg_ready is always high. One command is worked on at
//   a time; s_tready is high only while idle. The multiply cost is set by the single MAC
//   unit fed from one B read port, one product per cycle, plus a copy of each row of A
//   into the row buffer.
//   A stalled m_tready holds the result register; the next command may be accepted
//   meanwhile, and its result waits until the register frees up.
//   After reset both matrices read as zero (per-entry valid bits), n is 8, and the
//   block is ready at once.
module matrix_add_sub_multiply_engine_unit #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config: size in use
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mase_pkg::DIM_W-1:0]   cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,  // [2:0] row, [5:3] col, [37:6] value
    input  logic [2:0]                   s_tuser,  // [2:0] command
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // [31:0] read_value
    output logic [mase_pkg::STAT_W-1:0]  m_tuser   // [1:0] status
);
    import mase_pkg::*;

    localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned AW = 2 * IW;
    localparam int unsigned NW = $clog2(MAX_DIM + 1);
    localparam int unsigned CW = (NW > DIM_W) ? NW : DIM_W;

    // ---------------- registers ----------------
    mase_state_t        state_reg, state_next;
    mase_cmd_t          cmd_reg, cmd_next;
    logic [DIM_W-1:0]   dim_reg;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      wcol_reg, wcol_next;
    logic               sat_reg, sat_next;
    logic               idx_err_reg, idx_err_next;
    logic [ELEM_W-1:0]  res_val_reg, res_val_next;
    logic               cp_vld_reg, cp_vld_next;
    logic [IW-1:0]      cp_j_reg, cp_j_next;
    logic               as_vld_reg, as_vld_next;
    logic [AW-1:0]      as_addr_reg, as_addr_next;
    logic [ELEM_W-1:0]  row_buf [MAX_DIM];
    logic [ELEM_W-1:0]  rb_q_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]  m_tuser_reg, m_tuser_next;

    // ---------------- store and MAC hookup ----------------
    logic               a_clear, a_we, b_we;
    logic [AW-1:0]      a_waddr, a_raddr, b_waddr, b_raddr;
    logic [ELEM_W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;
    mac_tag_t           mac_tag;
    logic               mac_valid, mac_sat;
    logic [ELEM_W-1:0]  mac_data;

    // ---------------- decode ----------------
    mase_cmd_t          in_cmd;
    logic [IDX_IN_W-1:0] in_row, in_col;
    logic [ELEM_W-1:0]  in_value;
    logic [AW-1:0]      in_addr;
    logic               in_oob;
    logic [NW-1:0]      n_eff;
    logic [IW-1:0]      nm1;
    logic signed [ELEM_W:0] as_sum;
    logic               as_ovf;
    logic [ELEM_W-1:0]  as_res;

    assign in_cmd   = mase_cmd_t'(s_tuser);
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];
    assign in_addr  = {IW'(in_row), IW'(in_col)};

    always_comb begin
        if (dim_reg == '0) begin
            n_eff = NW'(1);
        end else if (CW'(dim_reg) > CW'(MAX_DIM)) begin
            n_eff = NW'(MAX_DIM);
        end else begin
            n_eff = NW'(dim_reg);
        end
    end

    assign nm1    = IW'(n_eff - NW'(1));
    assign in_oob = (CW'(in_row) >= CW'(n_eff)) || (CW'(in_col) >= CW'(n_eff));

    // Add / subtract on the data coming back from both stores.
    assign as_sum = (cmd_reg == CMD_SUB)
                  ? $signed({a_rdata[ELEM_W-1], a_rdata}) - $signed({b_rdata[ELEM_W-1], b_rdata})
                  : $signed({a_rdata[ELEM_W-1], a_rdata}) + $signed({b_rdata[ELEM_W-1], b_rdata});
    assign as_ovf = as_sum[ELEM_W] != as_sum[ELEM_W-1];
    assign as_res = as_ovf ? (as_sum[ELEM_W] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : as_sum[ELEM_W-1:0];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    mase_store #(.ADDR_W(AW)) u_store_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (a_clear),
        .we      (a_we),
        .waddr   (a_waddr),
        .wdata   (a_wdata),
        .raddr   (a_raddr),
        .rdata   (a_rdata)
    );

    mase_store #(.ADDR_W(AW)) u_store_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (1'b0),
        .we      (b_we),
        .waddr   (b_waddr),
        .wdata   (b_wdata),
        .raddr   (b_raddr),
        .rdata   (b_rdata)
    );

    mase_mac #(.IDX_W(IW)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tag_in    (mac_tag),
        .op_a      (rb_q_reg),
        .op_b      (b_rdata),
        .res_valid (mac_valid),
        .res_data  (mac_data),
        .res_sat   (mac_sat)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        wcol_next     = wcol_reg;
        sat_next      = sat_reg;
        idx_err_next  = idx_err_reg;
        res_val_next  = res_val_reg;
        cp_vld_next   = 1'b0;
        cp_j_next     = cp_j_reg;
        as_vld_next   = 1'b0;
        as_addr_next  = as_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        a_clear       = 1'b0;
        a_we          = 1'b0;
        a_waddr       = '0;
        a_wdata       = '0;
        a_raddr       = '0;
        b_we          = 1'b0;
        b_waddr       = in_addr;
        b_wdata       = in_value;
        b_raddr       = '0;
        mac_tag       = '0;

        // Write back the element that came out of the add/subtract stage.
        if (as_vld_reg) begin
            a_we     = 1'b1;
            a_waddr  = as_addr_reg;
            a_wdata  = as_res;
            sat_next = sat_reg | as_ovf;
        end

        // Write back a finished dot product into the current row of A.
        if (mac_valid) begin
            a_we      = 1'b1;
            a_waddr   = {k_reg, wcol_reg};
            a_wdata   = mac_data;
            sat_next  = sat_reg | mac_sat;
            wcol_next = (wcol_reg == nm1) ? '0 : wcol_reg + IW'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    sat_next     = 1'b0;
                    idx_err_next = 1'b0;
                    res_val_next = '0;
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    wcol_next    = '0;
                    unique case (in_cmd)
                        CMD_WRITE_A, CMD_READ_A, CMD_WRITE_B: begin
                            if (in_oob) begin
                                idx_err_next = 1'b1;
                                state_next   = ST_FIN;
                            end else if (in_cmd == CMD_WRITE_A) begin
                                a_we       = 1'b1;
                                a_waddr    = in_addr;
                                a_wdata    = in_value;
                                state_next = ST_FIN;
                            end else if (in_cmd == CMD_WRITE_B) begin
                                b_we       = 1'b1;
                                state_next = ST_FIN;
                            end else begin
                                a_raddr    = in_addr;
                                state_next = ST_READ;
                            end
                        end
                        CMD_ADD, CMD_SUB: begin
                            state_next = ST_ADDSUB;
                        end
                        CMD_MUL: begin
                            state_next = ST_COPY;
                        end
                        CMD_CLEAR: begin
                            a_clear    = 1'b1;
                            state_next = ST_FIN;
                        end
                        CMD_IDENT: begin
                            a_clear    = 1'b1;
                            state_next = ST_IDENT;
                        end
                    endcase
                end
            end

            ST_READ: begin
                res_val_next = a_rdata;
                state_next   = ST_FIN;
            end

            ST_IDENT: begin
                a_we    = 1'b1;
                a_waddr = {i_reg, i_reg};
                a_wdata = Q_ONE;
                if (i_reg == nm1) begin
                    state_next = ST_FIN;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end

            ST_ADDSUB: begin
                a_raddr      = {i_reg, j_reg};
                b_raddr      = {i_reg, j_reg};
                as_vld_next  = 1'b1;
                as_addr_next = {i_reg, j_reg};
                if (j_reg == nm1) begin
                    j_next = '0;
                    if (i_reg == nm1) begin
                        state_next = ST_AS_DRAIN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end

            ST_AS_DRAIN: begin
                state_next = ST_FIN;
            end

            ST_COPY: begin
                a_raddr     = {k_reg, j_reg};
                cp_vld_next = 1'b1;
                cp_j_next   = j_reg;
                if (j_reg == nm1) begin
                    j_next     = '0;
                    state_next = ST_SETTLE;
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end

            ST_SETTLE: begin
                // let the last copied element land in the row buffer
                state_next = ST_MAC;
            end

            ST_MAC: begin
                b_raddr       = {j_reg, i_reg};
                mac_tag.vld   = 1'b1;
                mac_tag.first = (j_reg == '0);
                mac_tag.last  = (j_reg == nm1);
                if (j_reg == nm1) begin
                    j_next = '0;
                    if (i_reg == nm1) begin
                        i_next     = '0;
                        state_next = ST_MAC_DRAIN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end

            ST_MAC_DRAIN: begin
                if (mac_valid && (wcol_reg == nm1)) begin
                    if (k_reg == nm1) begin
                        state_next = ST_FIN;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = ST_COPY;
                    end
                end
            end

            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_val_reg;
                    priority if (idx_err_reg) begin
                        m_tuser_next = STAT_IDX;
                    end else if (sat_reg) begin
                        m_tuser_next = STAT_SAT;
                    end else begin
                        m_tuser_next = STAT_OK;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dim_reg      <= DIM_RESET;
            cp_vld_reg   <= 1'b0;
            as_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= CMD_WRITE_A;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            wcol_reg     <= '0;
            sat_reg      <= 1'b0;
            idx_err_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cp_vld_reg   <= cp_vld_next;
            as_vld_reg   <= as_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            cmd_reg      <= cmd_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            wcol_reg     <= wcol_next;
            sat_reg      <= sat_next;
            idx_err_reg  <= idx_err_next;
            if (cfg_valid && cfg_ready) begin
                dim_reg <= cfg_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        res_val_reg <= res_val_next;
        cp_j_reg    <= cp_j_next;
        as_addr_reg <= as_addr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        rb_q_reg    <= row_buf[j_reg];
        if (cp_vld_reg) begin
            row_buf[cp_j_reg] <= a_rdata;
        end
    end

endmodule

FILE: tb/matrix_add_sub_multiply_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_add_sub_multiply_engine_unit: directed vectors,
// then random command mixes at several matrix sizes, checked by an in-bench model.
// Depends on mase_pkg and the engine top level only.
module matrix_add_sub_multiply_engine_unit_tb;
    import mase_pkg::*;

    localparam int unsigned MAX_DIM = 8;
    localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
    localparam int unsigned ITEMS_PER_SIZE = 75;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam longint ELEM_MAX = 64'sd2147483647;
    localparam longint ELEM_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] read_value;
        logic [1:0]  status;
    } result_t;

    typedef struct {
        bit          is_size;
        logic [3:0]  size;
        mase_cmd_t   op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        bit          typed;
        logic [31:0] read_value;
        logic [1:0]  status;
    } vec_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata = '0;   // [2:0] row, [5:3] col, [37:6] value
    logic [2:0]           s_tuser = '0;   // [2:0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // [31:0] read_value
    logic [STAT_W-1:0]    m_tuser;        // [1:0] status

    // shadow state of the engine
    logic [31:0] elem_a [CELLS];
    logic [31:0] elem_b [CELLS];
    logic [31:0] row_hold [MAX_DIM];
    logic [3:0]  size_reg;

    result_t     pending_results[$];
    vec_t        dir_vec[$];
    int          mismatch_count = 0;
    longint      cycle_count = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    matrix_add_sub_multiply_engine_unit #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] clip32(input longint v, inout bit hit);
        if (v > ELEM_MAX) begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < ELEM_MIN) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic int unsigned size_in_use();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_DIM) return MAX_DIM;
        return 32'(size_reg);
    endfunction

    // Work out the result of one command and advance the shadow matrices.
    function automatic result_t apply_command(input mase_cmd_t op, input logic [2:0] r,
                                              input logic [2:0] k, input logic [31:0] v);
        result_t     res;
        int unsigned n;
        int unsigned idx;
        bit          clipped;
        longint      lhs;
        longint      rhs;
        longint      prod;
        longint      acc;
        n = size_in_use();
        res.read_value = '0;
        res.status = STAT_OK;
        clipped = 1'b0;
        case (op)
            CMD_WRITE_A, CMD_READ_A, CMD_WRITE_B: begin
                if (r >= n || k >= n) begin
                    res.status = STAT_IDX;
                end else begin
                    idx = r * MAX_DIM + k;
                    if (op == CMD_WRITE_A) elem_a[idx] = v;
                    else if (op == CMD_READ_A) res.read_value = elem_a[idx];
                    else elem_b[idx] = v;
                end
            end
            CMD_ADD, CMD_SUB: begin
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        idx = i * MAX_DIM + j;
                        lhs = longint'($signed(elem_a[idx]));
                        rhs = longint'($signed(elem_b[idx]));
                        elem_a[idx] = clip32(op == CMD_ADD ? lhs + rhs : lhs - rhs, clipped);
                    end
                end
            end
            CMD_MUL: begin
                // row k of A is buffered before it is overwritten
                for (int kr = 0; kr < n; kr++) begin
                    for (int j = 0; j < n; j++) row_hold[j] = elem_a[kr * MAX_DIM + j];
                    for (int i = 0; i < n; i++) begin
                        acc = 0;
                        for (int j = 0; j < n; j++) begin
                            prod = longint'($signed(row_hold[j])) *
                                   longint'($signed(elem_b[j * MAX_DIM + i]));
                            acc += (prod + 64'sd32768) >>> 16;
                        end
                        elem_a[kr * MAX_DIM + i] = clip32(acc, clipped);
                    end
                end
            end
            default: begin
                for (int i = 0; i < CELLS; i++) elem_a[i] = '0;
                if (op == CMD_IDENT)
                    for (int i = 0; i < n; i++) elem_a[i * MAX_DIM + i] = Q_ONE;
            end
        endcase
        if (clipped) res.status = STAT_SAT;
        return res;
    endfunction

    function automatic vec_t cmd_row(input mase_cmd_t op, input logic [2:0] r,
                                     input logic [2:0] k, input logic [31:0] v,
                                     input bit typed, input logic [31:0] rd,
                                     input logic [1:0] st);
        vec_t e;
        e.is_size = 1'b0;
        e.size = '0;
        e.op = op;
        e.row = r;
        e.col = k;
        e.value = v;
        e.typed = typed;
        e.read_value = rd;
        e.status = st;
        return e;
    endfunction

    function automatic vec_t size_row(input logic [3:0] sz);
        vec_t e;
        e = cmd_row(CMD_READ_A, 0, 0, 0, 1'b0, 0, STAT_OK);
        e.is_size = 1'b1;
        e.size = sz;
        return e;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input vec_t e);
        dir_vec.insert(dir_vec.size(), e);
    endfunction

    // Send one command; typed rows carry their own expectation, the rest use the model.
    task automatic issue_command(input mase_cmd_t op, input logic [2:0] r,
                                 input logic [2:0] k, input logic [31:0] v,
                                 input bit typed, input logic [31:0] rd,
                                 input logic [1:0] st);
        result_t res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, v, k, r};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        res = apply_command(op, r, k, v);
        if (typed) begin
            res.read_value = rd;
            res.status = st;
        end
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_size(input logic [3:0] sz);
        cfg_valid <= 1'b1;
        cfg_data <= sz;
        do @(posedge aclk); while (!cfg_ready);
        size_reg = sz;
        cfg_valid <= 1'b0;
    endtask

    // result sink with random back-pressure bursts
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer, read_value %h status %0d",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int          sizes [12];
        int unsigned n;
        int          pick;
        mase_cmd_t   op;
        logic [2:0]  r;
        logic [2:0]  k;
        logic [31:0] v;
        logic [31:0] corner_vals [8];

        sizes = '{3, 8, 1, 0, 15, 5, 2, 9, 4, 6, 7, 8};
        corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000};
        for (int i = 0; i < CELLS; i++) begin
            elem_a[i] = '0;
            elem_b[i] = '0;
        end
        for (int i = 0; i < MAX_DIM; i++) row_hold[i] = '0;
        size_reg = DIM_RESET;

        // saturation and identity corners, multiply and clear, then size handling
        add_row(cmd_row(CMD_READ_A, 0, 0, 32'h0, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_READ_A, 7, 7, 32'hFFFF_FFFF, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_WRITE_A, 0, 0, 32'h7FFF_FFFF, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_WRITE_B, 0, 0, 32'h7FFF_FFFF, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_ADD, 0, 0, 32'h0, 1, 32'h0, STAT_SAT));
        add_row(cmd_row(CMD_READ_A, 0, 0, 32'h0, 1, 32'h7FFF_FFFF, STAT_OK));
        add_row(cmd_row(CMD_WRITE_A, 7, 7, 32'h8000_0000, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_WRITE_B, 7, 7, 32'h0000_0001, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_SUB, 7, 7, 32'h0, 1, 32'h0, STAT_SAT));
        add_row(cmd_row(CMD_READ_A, 7, 7, 32'h0, 1, 32'h8000_0000, STAT_OK));
        add_row(cmd_row(CMD_IDENT, 0, 0, 32'h0, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_READ_A, 3, 3, 32'h0, 1, Q_ONE, STAT_OK));
        add_row(cmd_row(CMD_MUL, 0, 0, 32'h0, 0, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_READ_A, 7, 7, 32'h0, 0, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_CLEAR, 0, 0, 32'h0, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_READ_A, 0, 0, 32'h0, 1, 32'h0, STAT_OK));
        add_row(size_row(4'd2));
        add_row(cmd_row(CMD_WRITE_A, 2, 0, 32'h1234_5678, 1, 32'h0, STAT_IDX));
        add_row(cmd_row(CMD_READ_A, 0, 2, 32'h0, 1, 32'h0, STAT_IDX));
        add_row(cmd_row(CMD_WRITE_B, 1, 5, 32'h5555_AAAA, 1, 32'h0, STAT_IDX));
        add_row(cmd_row(CMD_WRITE_B, 1, 1, 32'hFFFF_0000, 0, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_ADD, 0, 0, 32'h0, 0, 32'h0, STAT_OK));
        // size 0 acts as 1: half-up rounding of a tiny product
        add_row(size_row(4'd0));
        add_row(cmd_row(CMD_WRITE_A, 0, 0, 32'h0000_8000, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_WRITE_B, 0, 0, 32'h0000_0001, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_MUL, 0, 0, 32'h0, 1, 32'h0, STAT_OK));
        add_row(cmd_row(CMD_READ_A, 0, 0, 32'h0, 1, 32'h0000_0001, STAT_OK));
        add_row(cmd_row(CMD_WRITE_A, 1, 0, 32'h0, 1, 32'h0, STAT_IDX));
        add_row(size_row(4'd15));
        add_row(cmd_row(CMD_READ_A, 7, 7, 32'h0, 1, 32'h0, STAT_OK));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_vec[i]) begin
            if (dir_vec[i].is_size) begin
                drain_results();
                write_size(dir_vec[i].size);
            end else begin
                issue_command(dir_vec[i].op, dir_vec[i].row, dir_vec[i].col,
                              dir_vec[i].value, dir_vec[i].typed,
                              dir_vec[i].read_value, dir_vec[i].status);
            end
        end

        foreach (sizes[p]) begin
            drain_results();
            write_size(4'(sizes[p]));
            // final stretch runs at full rate on both sides
            idle_on = (p != $size(sizes) - 1);
            n = size_in_use();
            for (int t = 0; t < ITEMS_PER_SIZE; t++) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) op = CMD_WRITE_A;
                else if (pick < 42) op = CMD_WRITE_B;
                else if (pick < 62) op = CMD_READ_A;
                else if (pick < 70) op = CMD_ADD;
                else if (pick < 78) op = CMD_SUB;
                else if (pick < 86) op = CMD_MUL;
                else if (pick < 91) op = CMD_CLEAR;
                else if (pick < 96) op = CMD_IDENT;
                else op = mase_cmd_t'(3'($urandom_range(0, 7)));
                if (pick >= 96 || $urandom_range(0, 9) == 0) begin
                    r = 3'($urandom_range(0, 7));
                    k = 3'($urandom_range(0, 7));
                end else begin
                    r = 3'($urandom_range(0, n - 1));
                    k = 3'($urandom_range(0, n - 1));
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) v = $urandom_range(0, 32'h7FFFF) - 32'h40000;
                else if (pick < 85) v = $urandom;
                else v = corner_vals[$urandom_range(0, 7)];
                issue_command(op, r, k, v, 1'b0, 32'h0, STAT_OK);
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
